@@ rtl/core/xmbt_pkg.sv @@
package xmbt_pkg;

	localparam int WEIGHT_WIDTH = 24;
	localparam int SIG_ENTRIES  = 256;
	localparam int IDX_W        = $clog2(SIG_ENTRIES);
	localparam int MUL_W        = ((WEIGHT_WIDTH > 17) ? WEIGHT_WIDTH : 17) + 1;
	localparam int PROD_W       = 2 * MUL_W;
	localparam int ACC_W        = PROD_W + 2;
	localparam longint SPAN     = 524288;

	typedef logic signed [WEIGHT_WIDTH-1:0] weight_t;
	typedef logic [15:0] act_t;
	typedef act_t sig_tab_t [SIG_ENTRIES];

	localparam logic [1:0] MODE_TRAIN = 2'd0;
	localparam logic [1:0] MODE_INFER = 2'd1;
	localparam logic [1:0] MODE_LOAD  = 2'd2;

	localparam logic REG_LEARNING_RATE = 1'b0;
	localparam logic REG_BIAS_VALUE    = 1'b1;

	// Restoring division, used only while building constants
	function automatic logic [63:0] udiv(logic [63:0] n, logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r    = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// e^(-t) in Q0.32 for t in Q16, 0 <= t <= 8.0
	function automatic logic [63:0] exp_neg(logic [63:0] t);
		logic [63:0] s;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic [63:0] r;
		s    = t << 12;
		term = 64'd1 << 32;
		sum  = signed'(term);
		for (int k = 1; k <= 10; k++) begin
			term = udiv((term * s) >> 32, 64'(k));
			if (k % 2 == 1)
				sum = sum - signed'(term);
			else
				sum = sum + signed'(term);
		end
		if (sum < 0)
			sum = 0;
		r = unsigned'(sum);
		if (r > 64'hFFFF_FFFF)
			r = 64'hFFFF_FFFF;
		for (int k = 0; k < 4; k++)
			r = (r * r) >> 32;
		return r;
	endfunction

	function automatic act_t sig_eval(longint x);
		longint t;
		logic [63:0] e;
		logic [63:0] p;
		t = (x < 0) ? -x : x;
		e = exp_neg(64'(t));
		p = udiv(64'd1 << 48, (64'd1 << 32) + e);
		if (x >= 0)
			return (p > 64'd65535) ? 16'hFFFF : p[15:0];
		return 16'(64'd65536 - p);
	endfunction

	function automatic sig_tab_t build_sig_tab();
		sig_tab_t tab;
		longint mid;
		for (int i = 0; i < SIG_ENTRIES; i++) begin
			mid = -SPAN + longint'(udiv(64'((2 * i + 1)) * 64'(SPAN), 64'(SIG_ENTRIES)));
			tab[i] = sig_eval(mid);
		end
		return tab;
	endfunction

	function automatic weight_t clamp_w(longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (WEIGHT_WIDTH - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return weight_t'(hi);
		if (v < lo)
			return weight_t'(lo);
		return weight_t'(v);
	endfunction

	localparam sig_tab_t SIG_TAB = build_sig_tab();
	localparam weight_t  W_INIT  = clamp_w(32768);
	localparam weight_t  PRESET [7] = '{clamp_w(173015), clamp_w(-464781), clamp_w(-464650),
		clamp_w(336855), clamp_w(336527), clamp_w(-513409), clamp_w(758579)};

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	typedef enum logic [4:0] {
		SP_HB, SP_HX0, SP_HX1, SP_HSUM, SP_HSIG,
		SP_OH, SP_OB, SP_OX0, SP_OX1, SP_OSUM, SP_OSIG,
		SP_D1, SP_D2, SP_DOUT, SP_SQ, SP_T2, SP_GO, SP_D3, SP_DHID,
		SP_W6, SP_GH, SP_W5, SP_W3, SP_W4, SP_W0, SP_W1, SP_W2
	} step_t;

endpackage

@@ rtl/core/xor_mlp_backprop_trainer.sv @@
// Channel   Direction  Words carried
// s_*       in         x_first, x_second, target in tdata; mode in tuser
// m_*       out        net_output, squared_error in tdata
// APB       in/out     learning_rate (0x0), bias_value (0x4)
//
// One shared signed multiplier under a step sequencer does every multiplication,
// one product a cycle while running. Infer and load run steps SP_HB to
// SP_OSIG, a training step on to SP_W2; the finish state then loads the word.
// arst_n clears control state, weights go to 0.5 and registers to defaults.
// s_tready is high only while idle. A finished word waits in the output
// register until taken; the finish state holds while an earlier one waits.
module xor_mlp_backprop_trainer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // x_first, x_second, target
	input  logic [1:0]  s_tuser,  // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // net_output, squared_error
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import xmbt_pkg::*;

	typedef logic signed [MUL_W-1:0] op_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	state_t state_q;
	step_t  step_q;

	logic [15:0] lr_q;
	logic signed [15:0] bias_q;
	weight_t w_q [7];

	logic signed [15:0] x0_q, x1_q;
	logic [15:0] tgt_q;
	logic [1:0]  mode_q;

	act_t h_q, o_q, sq_q;
	op_t  dout_q, t2_q, go_q, dhid_q, gh_q;
	logic signed [PROD_W-1:0] prod_q;
	acc_t acc_q;

	op_t op_a, op_b;
	op_t err;
	acc_t prod_x;

	// APB: always ready, write on the access cycle
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_LEARNING_RATE: prdata = {16'd0, lr_q};
			REG_BIAS_VALUE:    prdata = {{16{bias_q[15]}}, bias_q};
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q   <= 16'd16384;
			bias_q <= 16'sd4096;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_LEARNING_RATE: lr_q   <= pwdata[15:0];
				REG_BIAS_VALUE:    bias_q <= signed'(pwdata[15:0]);
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	// err = target - output, Q0.16 signed
	assign err    = op_t'($signed({2'b00, tgt_q}) - $signed({2'b00, o_q}));
	assign prod_x = acc_t'(prod_q);

	function automatic act_t sig_lookup(acc_t acc);
		acc_t net;
		logic [19:0] u;
		logic [IDX_W+20:0] scaled;
		logic [IDX_W-1:0] idx;
		net = acc >>> 12;
		if (net < -acc_t'(SPAN))
			idx = '0;
		else if (net > acc_t'(SPAN - 1))
			idx = IDX_W'(SIG_ENTRIES - 1);
		else begin
			u      = 20'(net + acc_t'(SPAN));
			scaled = (IDX_W + 21)'(u) * (IDX_W + 21)'(SIG_ENTRIES);
			idx    = scaled[IDX_W+19:20];
		end
		return SIG_TAB[idx];
	endfunction

	function automatic weight_t sat_add(weight_t w, acc_t d);
		logic signed [ACC_W:0] s;
		logic signed [ACC_W:0] hi;
		logic signed [ACC_W:0] lo;
		hi = (ACC_W + 1)'((longint'(1) <<< (WEIGHT_WIDTH - 1)) - 1);
		lo = -hi - 1;
		s  = (ACC_W + 1)'(w) + (ACC_W + 1)'(d);
		if (s > hi)
			return weight_t'(hi);
		if (s < lo)
			return weight_t'(lo);
		return weight_t'(s);
	endfunction

	// Operand selection for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (step_q)
			SP_HB:   begin op_a = op_t'(bias_q); op_b = op_t'(w_q[0]); end
			SP_HX0:  begin op_a = op_t'(x0_q);   op_b = op_t'(w_q[1]); end
			SP_HX1:  begin op_a = op_t'(x1_q);   op_b = op_t'(w_q[2]); end
			SP_OH:   begin op_a = op_t'({1'b0, h_q}); op_b = op_t'(w_q[6]); end
			SP_OB:   begin op_a = op_t'(bias_q); op_b = op_t'(w_q[5]); end
			SP_OX0:  begin op_a = op_t'(x0_q);   op_b = op_t'(w_q[3]); end
			SP_OX1:  begin op_a = op_t'(x1_q);   op_b = op_t'(w_q[4]); end
			SP_D1:   begin
				op_a = op_t'({1'b0, o_q});
				op_b = op_t'(18'sd65536 - $signed({2'b00, o_q}));
			end
			SP_D2:   begin op_a = op_t'(prod_q >>> 16); op_b = err; end
			SP_DOUT: begin op_a = err; op_b = err; end
			SP_SQ:   begin op_a = op_t'(w_q[6]); op_b = dout_q; end
			SP_T2:   begin op_a = op_t'({1'b0, lr_q}); op_b = dout_q; end
			SP_GO:   begin
				op_a = op_t'({1'b0, h_q});
				op_b = op_t'(18'sd65536 - $signed({2'b00, h_q}));
			end
			SP_D3:   begin op_a = op_t'(prod_q >>> 16); op_b = t2_q; end
			SP_DHID: begin op_a = go_q; op_b = op_t'({1'b0, h_q}); end
			SP_W6:   begin op_a = op_t'({1'b0, lr_q}); op_b = dhid_q; end
			SP_GH:   begin op_a = go_q; op_b = op_t'(bias_q); end
			SP_W5:   begin op_a = go_q; op_b = op_t'(x0_q); end
			SP_W3:   begin op_a = go_q; op_b = op_t'(x1_q); end
			SP_W4:   begin op_a = gh_q; op_b = op_t'(bias_q); end
			SP_W0:   begin op_a = gh_q; op_b = op_t'(x0_q); end
			SP_W1:   begin op_a = gh_q; op_b = op_t'(x1_q); end
			default: ;
		endcase
	end

	// Sequencer: each step issues one product and consumes the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= SP_HB;
			m_tvalid <= 1'b0;
			for (int i = 0; i < 7; i++)
				w_q[i] <= W_INIT;
		end else begin
			// drop a taken word; the finish state reloads it itself
			if (m_tvalid && m_tready && (state_q != ST_FIN))
				m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						x0_q   <= signed'(s_tdata[15:0]);
						x1_q   <= signed'(s_tdata[31:16]);
						tgt_q  <= s_tdata[47:32];
						mode_q <= s_tuser;
						if (s_tuser == MODE_LOAD)
							for (int i = 0; i < 7; i++)
								w_q[i] <= PRESET[i];
						step_q  <= SP_HB;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					prod_q <= op_a * op_b;
					step_q <= (step_q == SP_W2) ? SP_HB : step_t'(step_q + 5'd1);
					case (step_q)
						SP_HX0:  acc_q <= prod_x;
						SP_HX1, SP_HSUM, SP_OX0, SP_OX1, SP_OSUM:
							acc_q <= acc_q + prod_x;
						SP_HSIG: h_q <= sig_lookup(acc_q);
						SP_OB:   acc_q <= prod_x >>> 4;
						SP_OSIG: begin
							o_q <= sig_lookup(acc_q);
							if (mode_q != MODE_TRAIN)
								state_q <= ST_FIN;
						end
						SP_DOUT: dout_q <= op_t'(prod_x >>> 16);
						SP_SQ:   begin
							if ((prod_x >>> 16) > acc_t'(65535))
								sq_q <= 16'hFFFF;
							else
								sq_q <= 16'(prod_x >>> 16);
						end
						SP_T2:   t2_q   <= op_t'(prod_x >>> 16);
						SP_GO:   go_q   <= op_t'(prod_x >>> 16);
						SP_DHID: dhid_q <= op_t'(prod_x >>> 16);
						SP_W6:   w_q[6] <= sat_add(w_q[6], prod_x >>> 16);
						SP_GH:   gh_q   <= op_t'(prod_x >>> 16);
						SP_W5:   w_q[5] <= sat_add(w_q[5], prod_x >>> 12);
						SP_W3:   w_q[3] <= sat_add(w_q[3], prod_x >>> 12);
						SP_W4:   w_q[4] <= sat_add(w_q[4], prod_x >>> 12);
						SP_W0:   w_q[0] <= sat_add(w_q[0], prod_x >>> 12);
						SP_W1:   w_q[1] <= sat_add(w_q[1], prod_x >>> 12);
						SP_W2:   begin
							w_q[2]  <= sat_add(w_q[2], prod_x >>> 12);
							state_q <= ST_FIN;
						end
						default: ;
					endcase
				end
				ST_FIN: begin
					// hold until the previous word has gone
					if (!m_tvalid || m_tready) begin
						m_tdata  <= {(mode_q == MODE_TRAIN) ? sq_q : 16'd0, o_q};
						m_tvalid <= 1'b1;
						step_q   <= SP_HB;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The step counter rests at its first step while idle
	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (step_q == SP_HB))
		else $error("step counter moved outside a run");

	// An accepted word always starts a run
	a_accept_run: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_RUN))
		else $error("accepted word did not start a run");

	// A new result word appears only on leaving the finish state
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_FIN))
		else $error("result word raised outside the finish state");

endmodule
